// ===== rtl/first_fit_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ffba check failed");

// next-cycle implication
`define FFBA_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ffba check failed");

`endif

// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Sizes, header layout, command and status codes, block-walk helper.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int HEAP_BYTES    = 1048576;
	localparam int GRANULE_BYTES = 8;
	localparam int GSH           = $clog2(GRANULE_BYTES);
	localparam int GRANULES      = HEAP_BYTES / GRANULE_BYTES;
	localparam int GW            = $clog2(GRANULES);
	localparam int BYTES_W       = 21;
	localparam int OFF_W         = 21;
	localparam int NEED_W        = $clog2(((((1 << BYTES_W) - 1) + GRANULE_BYTES - 1) >> GSH) + 2);
	localparam int ARG_W         = (NEED_W > GW + 1) ? NEED_W : GW + 1;
	localparam int QDEPTH        = 4;
	localparam int QAW           = $clog2(QDEPTH);

	typedef logic [GW-1:0] gidx_t;

	localparam gidx_t BLOCK_GRANULES = GW'(GRANULES - 1);

	typedef struct packed {
		gidx_t prev;
		logic  used;
		gidx_t size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);
	localparam hdr_t HDR_RESET = '{prev: '0, used: 1'b0, size: BLOCK_GRANULES};

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FAILED    = 2'd1,
		ST_FREED     = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_FAIL,
		CMD_IGNORE
	} cmd_kind_t;

	// arg: granules needed for an allocate, block index for a free
	typedef struct packed {
		cmd_kind_t        kind;
		logic [ARG_W-1:0] arg;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_WALK_A,
		BK_A_SPLIT,
		BK_A_FIX,
		BK_WALK_F,
		BK_F_NEXT,
		BK_F_NFIX,
		BK_F_PREV,
		BK_F_PQ,
		BK_F_QFIX,
		BK_RESP
	} bk_state_t;

	// start of the block after g, or BLOCK_GRANULES past the last block
	function automatic gidx_t follow_blk(gidx_t g, gidx_t size, gidx_t last);
		logic [GW:0] sum;
		sum = {1'b0, g} + {1'b0, size};
		if (g >= last) return BLOCK_GRANULES;
		if (sum < {1'b0, BLOCK_GRANULES}) return sum[GW-1:0];
		return BLOCK_GRANULES;
	endfunction

endpackage

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ffba_front.sv =====
// ----------------------------------------------------------------------------
// Allocator front end
// Takes request items, decodes them and queues a command per item.
// ----------------------------------------------------------------------------
module ffba_front
	import ffba_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // request_bytes [20:0], release_offset [41:21]
	input  logic [0:0]  s_tuser,  // operation [0]
	input  q_status_t   q_status,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [BYTES_W-1:0]     req_bytes;
	logic [OFF_W-1:0]       rel_off;
	logic [BYTES_W:0]       rnd;
	logic [NEED_W-1:0]      need;
	logic [OFF_W-GSH-1:0]   blk;
	logic                   bad_free;

	assign req_bytes = s_tdata[BYTES_W-1:0];
	assign rel_off   = s_tdata[BYTES_W+OFF_W-1:BYTES_W];

	assign rnd  = {1'b0, req_bytes} + (BYTES_W+1)'(GRANULE_BYTES - 1);
	assign need = NEED_W'(rnd >> GSH) + NEED_W'(1);
	assign blk  = rel_off[OFF_W-1:GSH] - (OFF_W-GSH)'(1);

	assign bad_free = (rel_off == '0) || (rel_off[GSH-1:0] != '0)
		|| (ARG_W'(blk) >= ARG_W'(BLOCK_GRANULES));

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_cmd = '{kind: CMD_FAIL, arg: '0};
		if (op_t'(s_tuser[0]) == OP_ALLOC) begin
			if (req_bytes == '0) begin
				push_cmd.kind = CMD_FAIL;
			end else begin
				push_cmd.kind = CMD_ALLOC;
				push_cmd.arg  = ARG_W'(need);
			end
		end else begin
			if (bad_free) begin
				push_cmd.kind = CMD_IGNORE;
			end else begin
				push_cmd.kind = CMD_FREE;
				push_cmd.arg  = ARG_W'(blk);
			end
		end
	end

endmodule

// ===== rtl/ffba_queue.sv =====
// ----------------------------------------------------------------------------
// Allocator command queue
// Small FIFO between the decoder and the header sequencer.
// ----------------------------------------------------------------------------
module ffba_queue
	import ffba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t status
);

	logic [QAW:0] wr_q;
	logic [QAW:0] rd_q;
	cmd_t         slot_q [QDEPTH];

	assign status.empty = (wr_q == rd_q);
	assign status.full  = (wr_q[QAW] != rd_q[QAW]) && (wr_q[QAW-1:0] == rd_q[QAW-1:0]);
	assign pop_cmd      = slot_q[rd_q[QAW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (QAW+1)'(1);
			end
			if (pop) begin
				rd_q <= rd_q + (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q[QAW-1:0]] <= push_cmd;
		end
	end

endmodule

// ===== rtl/ffba_back.sv =====
// ----------------------------------------------------------------------------
// Allocator header sequencer
// Walks block headers, splits and merges blocks, drives the result item.
// ----------------------------------------------------------------------------
module ffba_back
	import ffba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  q_status_t   q_status,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // payload_offset [20:0]
	output logic [1:0]  m_tuser   // status [1:0]
);

	localparam int OC_W = (GW + GSH + 1 > OFF_W) ? GW + GSH + 1 : OFF_W;

	bk_state_t state_q, state_d;

	cmd_t    cmd_q, cmd_d;
	gidx_t   g_q, g_d;
	gidx_t   n_q, n_d;
	gidx_t   nn_q, nn_d;
	gidx_t   qi_q, qi_d;
	gidx_t   tot_q, tot_d;
	hdr_t    hp_q, hp_d;
	status_t rstat_q, rstat_d;
	gidx_t   last_q, last_d;
	logic    h0_q;
	logic    zsel_s1;

	logic    out_valid_q;
	status_t out_stat_q;
	logic [OFF_W-1:0] out_off_q;
	logic    out_free;
	logic    out_ld;

	logic             we;
	gidx_t            wa;
	hdr_t             wd;
	gidx_t            ra;
	logic [HDR_W-1:0] rdata;
	hdr_t             hdr_r;

	logic  fit;
	logic  split;
	gidx_t nxt;
	gidx_t rest;
	gidx_t need_g;
	gidx_t nf;
	gidx_t pidx;
	gidx_t sum_np;
	gidx_t nn_n;
	logic  prev_ok;
	gidx_t qv;
	gidx_t tot2;
	gidx_t nn2;
	logic [OC_W-1:0] oc;

	ffba_ram #(
		.WIDTH(HDR_W),
		.DEPTH(GRANULES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wa),
		.wdata(wd),
		.raddr(ra),
		.rdata(rdata)
	);

	// entry 0 reads as one whole free block until first written
	assign hdr_r = zsel_s1 ? HDR_RESET : hdr_t'(rdata);

	assign need_g  = cmd_q.arg[GW-1:0];
	assign pidx    = cmd_q.arg[GW-1:0];
	assign fit     = !hdr_r.used && (ARG_W'(hdr_r.size) >= cmd_q.arg);
	assign rest    = hdr_r.size - need_g;
	assign split   = rest > gidx_t'(1);
	assign nf      = g_q + need_g;
	assign nxt     = follow_blk(g_q, hdr_r.size, last_q);
	assign sum_np  = hp_q.size + hdr_r.size;
	assign nn_n    = follow_blk(n_q, hdr_r.size, last_q);
	assign prev_ok = (pidx != '0) && (hp_q.prev != '0) && (hp_q.prev <= pidx);
	assign qv      = pidx - hp_q.prev;
	assign tot2    = hdr_r.size + tot_q;
	assign nn2     = follow_blk(pidx, tot_q, last_q);
	assign oc      = OC_W'({g_q, {GSH{1'b0}}}) + OC_W'(GRANULE_BYTES);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					unique case (q_cmd.kind)
						CMD_ALLOC:  state_d = BK_WALK_A;
						CMD_FREE:   state_d = BK_WALK_F;
						CMD_FAIL:   state_d = BK_RESP;
						CMD_IGNORE: state_d = BK_RESP;
						default:    state_d = BK_RESP;
					endcase
				end
			end
			BK_WALK_A: begin
				if (fit) begin
					state_d = split ? BK_A_SPLIT : BK_RESP;
				end else if (nxt >= BLOCK_GRANULES) begin
					state_d = BK_RESP;
				end
			end
			BK_A_SPLIT: state_d = (n_q < BLOCK_GRANULES) ? BK_A_FIX : BK_RESP;
			BK_A_FIX:   state_d = BK_RESP;
			BK_WALK_F: begin
				if (g_q == pidx) begin
					if (!hdr_r.used) begin
						state_d = BK_RESP;
					end else begin
						state_d = (nxt < BLOCK_GRANULES) ? BK_F_NEXT : BK_F_PREV;
					end
				end else if (nxt > pidx) begin
					state_d = BK_RESP;
				end
			end
			BK_F_NEXT: begin
				if (!hdr_r.used && nn_n < BLOCK_GRANULES) begin
					state_d = BK_F_NFIX;
				end else begin
					state_d = BK_F_PREV;
				end
			end
			BK_F_NFIX: state_d = BK_F_PREV;
			BK_F_PREV: state_d = prev_ok ? BK_F_PQ : BK_RESP;
			BK_F_PQ: begin
				if (!hdr_r.used && nn2 < BLOCK_GRANULES) begin
					state_d = BK_F_QFIX;
				end else begin
					state_d = BK_RESP;
				end
			end
			BK_F_QFIX: state_d = BK_RESP;
			BK_RESP: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		we      = 1'b0;
		wa      = g_q;
		wd      = hdr_r;
		ra      = g_q;
		out_ld  = 1'b0;
		cmd_d   = cmd_q;
		g_d     = g_q;
		n_d     = n_q;
		nn_d    = nn_q;
		qi_d    = qi_q;
		tot_d   = tot_q;
		hp_d    = hp_q;
		rstat_d = rstat_q;
		last_d  = last_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop   = 1'b1;
					cmd_d = q_cmd;
					g_d   = '0;
					ra    = '0;
					rstat_d = (q_cmd.kind == CMD_FAIL) ? ST_FAILED : ST_IGNORED;
				end
			end
			BK_WALK_A: begin
				if (fit) begin
					we      = 1'b1;
					wa      = g_q;
					rstat_d = ST_ALLOCATED;
					if (split) begin
						wd    = '{prev: hdr_r.prev, used: 1'b1, size: need_g};
						n_d   = nxt;
						nn_d  = nf;
						tot_d = rest;
					end else begin
						wd = '{prev: hdr_r.prev, used: 1'b1, size: hdr_r.size};
					end
				end else if (nxt >= BLOCK_GRANULES) begin
					rstat_d = ST_FAILED;
				end else begin
					g_d = nxt;
					ra  = nxt;
				end
			end
			BK_A_SPLIT: begin
				we = 1'b1;
				wa = nn_q;
				wd = '{prev: need_g, used: 1'b0, size: tot_q};
				ra = n_q;
				if (n_q >= BLOCK_GRANULES) begin
					last_d = nn_q;
				end
			end
			BK_A_FIX: begin
				we = 1'b1;
				wa = n_q;
				wd = '{prev: tot_q, used: hdr_r.used, size: hdr_r.size};
			end
			BK_WALK_F: begin
				rstat_d = ST_IGNORED;
				if (g_q == pidx) begin
					if (hdr_r.used) begin
						rstat_d = ST_FREED;
						hp_d    = hdr_r;
						n_d     = nxt;
						ra      = nxt;
						if (nxt >= BLOCK_GRANULES) begin
							we    = 1'b1;
							wa    = pidx;
							wd    = '{prev: hdr_r.prev, used: 1'b0, size: hdr_r.size};
							tot_d = hdr_r.size;
						end
					end
				end else if (nxt <= pidx) begin
					g_d = nxt;
					ra  = nxt;
				end
			end
			BK_F_NEXT: begin
				we = 1'b1;
				wa = pidx;
				if (!hdr_r.used) begin
					wd    = '{prev: hp_q.prev, used: 1'b0, size: sum_np};
					tot_d = sum_np;
					nn_d  = nn_n;
					ra    = nn_n;
					if (nn_n >= BLOCK_GRANULES) begin
						last_d = pidx;
					end
				end else begin
					wd    = '{prev: hp_q.prev, used: 1'b0, size: hp_q.size};
					tot_d = hp_q.size;
				end
			end
			BK_F_NFIX: begin
				we = 1'b1;
				wa = nn_q;
				wd = '{prev: tot_q, used: hdr_r.used, size: hdr_r.size};
			end
			BK_F_PREV: begin
				qi_d = qv;
				ra   = qv;
			end
			BK_F_PQ: begin
				if (!hdr_r.used) begin
					we    = 1'b1;
					wa    = qi_q;
					wd    = '{prev: hdr_r.prev, used: 1'b0, size: tot2};
					tot_d = tot2;
					nn_d  = nn2;
					ra    = nn2;
					if (nn2 >= BLOCK_GRANULES) begin
						last_d = qi_q;
					end
				end
			end
			BK_F_QFIX: begin
				we = 1'b1;
				wa = nn_q;
				wd = '{prev: tot_q, used: hdr_r.used, size: hdr_r.size};
			end
			BK_RESP: begin
				out_ld = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			last_q      <= '0;
			h0_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			if (we && wa == '0) begin
				h0_q <= 1'b1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		g_q     <= g_d;
		n_q     <= n_d;
		nn_q    <= nn_d;
		qi_q    <= qi_d;
		tot_q   <= tot_d;
		hp_q    <= hp_d;
		rstat_q <= rstat_d;
		zsel_s1 <= (ra == '0) && !h0_q;
		if (out_ld) begin
			out_stat_q <= rstat_q;
			out_off_q  <= (rstat_q == ST_ALLOCATED) ? oc[OFF_W-1:0] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {(24 - OFF_W)'(0), out_off_q};

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator
// Heap allocator over 8-byte granules with first-fit search, split and merge.
// ----------------------------------------------------------------------------
// Each request item gives exactly one result item, in order. Requests are
// decoded on entry and held in a four-item queue, so up to four items are
// taken while the sequencer is busy or a result waits. The sequencer reads
// one block header per cycle from the header RAM while it walks the blocks:
// an allocate walks to the first free block that fits and may split it, a
// free walks to the block named and may merge it with its free neighbours,
// and a failed allocate or a free of an offset that is not an allocated
// block start walks the blocks and then answers; zero-size allocates and
// null or invalid-offset frees are answered without a walk. After reset the
// whole region is one free block and no clearing pass is needed.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator
	import ffba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // request_bytes [20:0], release_offset [41:21]
	input  logic [0:0]  s_tuser,   // operation [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // payload_offset [20:0]
	output logic [1:0]  m_tuser    // status [1:0]
);

	q_status_t q_status;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      pop_cmd;

	ffba_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_status(q_status),
		.push    (push),
		.push_cmd(push_cmd)
	);

	ffba_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.status  (q_status)
	);

	ffba_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.q_cmd   (pop_cmd),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	`FFBA_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !q_status.empty)
	`FFBA_ASSERT_IMP(a_offset_only_on_grant, clk, arst_n,
		m_tvalid && (m_tuser != ST_ALLOCATED), m_tdata == '0)
	`FFBA_ASSERT_IMP(a_grant_aligned, clk, arst_n,
		m_tvalid && (m_tuser == ST_ALLOCATED), m_tdata[GSH-1:0] == '0)
	`FFBA_ASSERT_NXT(a_push_lands, clk, arst_n, push && !pop, !q_status.empty)

endmodule

// ===== tb/sv/allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit allocator reply checker
// Watches both stream channels. Keeps its own copy of the heap's block
// headers, works out the reply to every accepted request and compares each
// reply item, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module allocator_checker
	import ffba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // request_bytes [20:0], release_offset [41:21]
	input  logic [0:0]  s_tuser,   // operation [0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // payload_offset [20:0]
	input  logic [1:0]  m_tuser,   // status [1:0]
	output int unsigned owed_replies,
	output int unsigned mismatches
);

	typedef struct {
		status_t          status;
		logic [OFF_W-1:0] offset;
	} reply_t;

	gidx_t blk_size [GRANULES];
	gidx_t blk_prev [GRANULES];
	bit    blk_used [GRANULES];
	gidx_t last_start;

	reply_t      owed_q[$];
	int unsigned errors = 0;

	function automatic gidx_t next_start(gidx_t g);
		int unsigned n;
		if (g >= last_start) return BLOCK_GRANULES;
		n = 32'(g) + 32'(blk_size[g]);
		return (n < 32'(BLOCK_GRANULES)) ? gidx_t'(n) : BLOCK_GRANULES;
	endfunction

	// b is free and directly follows a
	function automatic void join_blocks(gidx_t a, gidx_t b);
		logic [GW:0] total;
		gidx_t       n;
		total = {1'b0, blk_size[a]} + {1'b0, blk_size[b]};
		n = next_start(b);
		blk_size[a] = gidx_t'(total);
		blk_used[a] = 1'b0;
		if (n < BLOCK_GRANULES)
			blk_prev[n] = gidx_t'(total);
		else
			last_start = a;
	endfunction

	function automatic bit grant_block(logic [BYTES_W-1:0] bytes, output gidx_t at);
		int unsigned need, steps, rest;
		gidx_t       g, n, nf;
		at = '0;
		if (bytes == 0) return 1'b0;
		need = (32'(bytes) + 32'd7) / GRANULE_BYTES + 1;
		g = '0;
		for (steps = 0; steps <= 32'(BLOCK_GRANULES); steps++) begin
			if (g >= BLOCK_GRANULES) return 1'b0;
			if (!blk_used[g] && 32'(blk_size[g]) >= need) break;
			g = next_start(g);
		end
		if (g >= BLOCK_GRANULES || steps > 32'(BLOCK_GRANULES)) return 1'b0;
		rest = 32'(blk_size[g]) - need;
		if (rest <= 1) begin
			blk_used[g] = 1'b1;
		end else begin
			n  = next_start(g);
			nf = gidx_t'(32'(g) + need);
			blk_size[g]  = gidx_t'(need);
			blk_used[g]  = 1'b1;
			blk_size[nf] = gidx_t'(rest);
			blk_used[nf] = 1'b0;
			blk_prev[nf] = gidx_t'(need);
			if (n < BLOCK_GRANULES)
				blk_prev[n] = gidx_t'(rest);
			else
				last_start = nf;
		end
		at = g;
		return 1'b1;
	endfunction

	function automatic status_t release_block(logic [OFF_W-1:0] off);
		int unsigned p, steps;
		gidx_t       pg, g, n, q;
		if (off == 0) return ST_IGNORED;
		if (off[GSH-1:0] != 0 || 32'(off) < GRANULE_BYTES) return ST_IGNORED;
		p = 32'(off) / GRANULE_BYTES - 1;
		if (p >= 32'(BLOCK_GRANULES)) return ST_IGNORED;
		pg = gidx_t'(p);
		g = '0;
		for (steps = 0; steps <= 32'(BLOCK_GRANULES) && g < pg; steps++)
			g = next_start(g);
		if (g != pg || !blk_used[pg]) return ST_IGNORED;
		n = next_start(pg);
		if (n < BLOCK_GRANULES && !blk_used[n])
			join_blocks(pg, n);
		else
			blk_used[pg] = 1'b0;
		if (pg > 0 && blk_prev[pg] <= pg) begin
			q = pg - blk_prev[pg];
			if (q != pg && !blk_used[q]) join_blocks(q, pg);
		end
		return ST_FREED;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		reply_t want;
		gidx_t  at;
		if (!arst_n) begin
			for (int i = 0; i < GRANULES; i++) begin
				blk_size[i] = '0;
				blk_prev[i] = '0;
				blk_used[i] = 1'b0;
			end
			blk_size[0] = BLOCK_GRANULES;
			last_start  = '0;
			owed_q.delete();
			owed_replies <= 0;
			mismatches   <= errors;
		end else begin
			// replies first: a request taken this edge cannot answer yet
			if (m_tvalid && m_tready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: reply item with none owed: status %0d offset %0d",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = owed_q.pop_front();
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, m_tuser);
						errors++;
					end
					if (m_tdata !== 24'(want.offset)) begin
						$display("%0t: payload offset expected %0d, got %0d",
							$time, want.offset, m_tdata);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser[0]) == OP_ALLOC) begin
					if (grant_block(s_tdata[BYTES_W-1:0], at))
						want = '{ST_ALLOCATED, OFF_W'((32'(at) + 1) * GRANULE_BYTES)};
					else
						want = '{ST_FAILED, '0};
				end else begin
					want = '{release_block(s_tdata[BYTES_W+OFF_W-1:BYTES_W]), '0};
				end
				owed_q.push_back(want);
			end
			owed_replies <= owed_q.size();
			mismatches   <= errors;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Drives allocate and free requests: a directed run through the corner
// cases, then random traffic of allocates, frees of live blocks and malformed
// requests, bursty and with a stalling reply side. Checking is in the checker.
// ----------------------------------------------------------------------------
module testbench;
	import ffba_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RANDOM_ITEMS = 1750;
	localparam int LIVE_CAP     = 48;
	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 64;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	int unsigned owed_replies;
	int unsigned mismatches;

	logic [OFF_W-1:0] live_offsets[$];
	logic [OFF_W-1:0] freed_offsets[$];

	always #(HALF_PERIOD) clk = ~clk;

	first_fit_block_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	allocator_checker reply_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.owed_replies (owed_replies),
		.mismatches   (mismatches)
	);

	// granted offsets feed the free traffic
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready && m_tuser == ST_ALLOCATED)
			live_offsets.push_back(m_tdata[OFF_W-1:0]);
	end

	task automatic send_request(op_t op, logic [BYTES_W-1:0] bytes, logic [OFF_W-1:0] off);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {6'b0, off, bytes};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic hold_off(int unsigned cycles);
		if (cycles == 0) return;
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata  = 48'({$urandom, $urandom});
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (owed_replies != 0) @(negedge clk);
	endtask

	task automatic send_random_request();
		int unsigned      pick, idx;
		logic [OFF_W-1:0] off;
		logic [BYTES_W-1:0] bytes;
		pick = $urandom_range(0, 99);
		if (live_offsets.size() >= LIVE_CAP && pick < 50) pick = 50;
		if (live_offsets.size() == 0 && pick >= 50 && pick < 92) pick = 0;
		if (pick < 50) begin
			idx = $urandom_range(0, 99);
			if (idx < 70)      bytes = BYTES_W'($urandom_range(1, 64));
			else if (idx < 90) bytes = BYTES_W'($urandom_range(65, 4096));
			else if (idx < 98) bytes = BYTES_W'($urandom_range(4097, 262144));
			else               bytes = BYTES_W'($urandom);
			send_request(OP_ALLOC, bytes, OFF_W'($urandom));
		end else if (pick < 92) begin
			idx = $urandom_range(0, live_offsets.size() - 1);
			off = live_offsets[idx];
			live_offsets.delete(idx);
			freed_offsets.push_back(off);
			if (freed_offsets.size() > 32) void'(freed_offsets.pop_front());
			send_request(OP_FREE, BYTES_W'($urandom), off);
		end else begin
			// malformed traffic
			off = (live_offsets.size() != 0) ?
				live_offsets[$urandom_range(0, live_offsets.size() - 1)] :
				OFF_W'(GRANULE_BYTES);
			case ($urandom_range(0, 5))
				0: send_request(OP_ALLOC, '0, OFF_W'($urandom));
				1: send_request(OP_FREE, BYTES_W'($urandom), '0);
				2: send_request(OP_FREE, BYTES_W'($urandom),
					OFF_W'(off + $urandom_range(1, 7)));
				3: send_request(OP_FREE, BYTES_W'($urandom), (freed_offsets.size() != 0) ?
					freed_offsets[$urandom_range(0, freed_offsets.size() - 1)] : off);
				4: send_request(OP_FREE, BYTES_W'($urandom),
					OFF_W'(off + GRANULE_BYTES * $urandom_range(1, 3)));
				default: send_request(OP_FREE, BYTES_W'($urandom), OFF_W'($urandom));
			endcase
		end
	endtask

	initial begin : receiver
		int unsigned mode, left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				0:       m_tready = 1'b1;
				1:       m_tready = $urandom_range(0, 1);
				default: m_tready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned sent, next_drain;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner cases on a fresh heap
		send_request(OP_ALLOC, '0, '1);
		send_request(OP_ALLOC, 21'd1, '0);
		send_request(OP_FREE, '1, '0);
		send_request(OP_FREE, '0, 21'd11);
		send_request(OP_FREE, '0, 21'd4);
		send_request(OP_FREE, '0, 21'h1FFFF8);
		send_request(OP_FREE, '0, 21'd16);
		send_request(OP_FREE, '0, OFF_W'(HEAP_BYTES - GRANULE_BYTES));
		send_request(OP_FREE, '0, 21'd8);
		send_request(OP_FREE, '0, 21'd8);
		// whole heap in one block, then too large ones, then a fit leaving one granule unsplit
		send_request(OP_ALLOC, BYTES_W'(HEAP_BYTES - 2 * GRANULE_BYTES), '0);
		send_request(OP_ALLOC, 21'd1, '0);
		send_request(OP_FREE, '0, 21'd8);
		send_request(OP_ALLOC, BYTES_W'(HEAP_BYTES - 2 * GRANULE_BYTES + 1), '0);
		send_request(OP_ALLOC, '1, '0);
		send_request(OP_ALLOC, BYTES_W'(HEAP_BYTES - 3 * GRANULE_BYTES), '0);
		send_request(OP_FREE, '0, 21'd8);
		// merge with both neighbours
		send_request(OP_ALLOC, 21'd8, '0);
		send_request(OP_ALLOC, 21'd16, '0);
		send_request(OP_ALLOC, 21'd24, '0);
		send_request(OP_ALLOC, 21'd8, '0);
		send_request(OP_FREE, '0, 21'd8);
		send_request(OP_FREE, '0, 21'd48);
		send_request(OP_FREE, '0, 21'd24);
		send_request(OP_ALLOC, 21'd56, '0);
		send_request(OP_FREE, '0, 21'd8);
		send_request(OP_FREE, '0, 21'd80);
		drain();
		live_offsets.delete();

		sent = 0;
		next_drain = 400;
		while (sent < RANDOM_ITEMS) begin
			repeat ($urandom_range(1, 16)) begin
				send_random_request();
				sent++;
			end
			if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
			if (sent >= next_drain) begin
				drain();
				next_drain += 400;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_front.sv
rtl/ffba_queue.sv
rtl/ffba_back.sv
rtl/first_fit_block_allocator.sv
tb/sv/allocator_checker.sv
tb/sv/testbench.sv
